// ===== hdl/ddwo_pkg.sv =====
// ddwo_pkg: types, constants and helper functions for the wheel odometry block
// used by ddwo_muldiv, ddwo_cordic and the top level; depends on nothing
`default_nettype none

package ddwo_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam logic [32:0] COUNTER_SPAN_DEF = 33'd65536;

	localparam logic [31:0] MPT_RESET = 32'd640710;
	localparam logic [31:0] IWB_RESET = 32'd81840078;
	localparam logic [14:0] WRAP_RESET = 15'd10000;

	localparam logic signed [33:0] PI_Q28 = 34'sd843314857;
	localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
	localparam logic signed [33:0] TWO_PI_Q28 = 34'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [63:0] ONE_Q40 = 64'd1 << 40;
	localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
	localparam logic [63:0] USEC_PER_SEC = 64'd1000000;

	typedef enum logic [1:0] {
		KIND_LEFT   = 2'd0,
		KIND_RIGHT  = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_START  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_MPT  = 2'd0,
		REG_IWB  = 2'd1,
		REG_WRAP = 2'd2
	} reg_t;

	typedef enum logic [1:0] {
		MD_MUL,
		MD_DIV,
		MD_SQRT
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_ctrl_t;

	typedef enum logic {
		CM_VECTOR,
		CM_ROTATE
	} cordic_mode_t;

	typedef struct packed {
		logic         start;
		cordic_mode_t mode;
	} cordic_ctrl_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CNT_MUL,
		ST_U_DIFF,
		ST_U_AM,
		ST_U_SQ,
		ST_U_SQRT,
		ST_U_ATAN,
		ST_U_WRAP,
		ST_U_FOLD,
		ST_U_ROT,
		ST_U_MX,
		ST_U_MY,
		ST_U_VL,
		ST_U_VLDIV,
		ST_U_VA,
		ST_U_VADIV,
		ST_FINISH
	} state_t;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:  r = 32'sd210828714;
			5'd1:  r = 32'sd124459457;
			5'd2:  r = 32'sd65760959;
			5'd3:  r = 32'sd33381290;
			5'd4:  r = 32'sd16755422;
			5'd5:  r = 32'sd8385879;
			5'd6:  r = 32'sd4193963;
			5'd7:  r = 32'sd2097109;
			5'd8:  r = 32'sd1048571;
			5'd9:  r = 32'sd524287;
			5'd10: r = 32'sd262144;
			5'd11: r = 32'sd131072;
			5'd12: r = 32'sd65536;
			5'd13: r = 32'sd32768;
			5'd14: r = 32'sd16384;
			5'd15: r = 32'sd8192;
			5'd16: r = 32'sd4096;
			5'd17: r = 32'sd2048;
			5'd18: r = 32'sd1024;
			5'd19: r = 32'sd512;
			5'd20: r = 32'sd256;
			5'd21: r = 32'sd128;
			5'd22: r = 32'sd64;
			5'd23: r = 32'sd32;
			5'd24: r = 32'sd16;
			5'd25: r = 32'sd8;
			5'd26: r = 32'sd4;
			5'd27: r = 32'sd2;
			5'd28: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] q);
		logic [63:0] nq;
		logic signed [31:0] r;
		nq = -q;
		if (!neg) begin
			r = (q > 64'd2147483647) ? 32'sh7fffffff : q[31:0];
		end else begin
			r = (q > 64'd2147483648) ? 32'sh80000000 : nq[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [33:0] wrap_angle(input logic signed [33:0] a);
		logic signed [33:0] r;
		if (a > PI_Q28) begin
			r = a - TWO_PI_Q28;
		end else if (a < -PI_Q28) begin
			r = a + TWO_PI_Q28;
		end else begin
			r = a;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ddwo_if.sv =====
// ddwo_in_if, ddwo_out_if: valid/ready channels for input and result words
// no package dependency
`default_nettype none

interface ddwo_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] count;
	logic [31:0]        elapsed_us;

	modport source (output valid, kind, count, elapsed_us, input ready);
	modport sink (input valid, kind, count, elapsed_us, output ready);
endinterface

interface ddwo_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [30:0] heading;
	logic signed [31:0] linear_velocity;
	logic signed [31:0] angular_velocity;
	logic               step_invalid;

	modport source (output valid, pos_x, pos_y, heading, linear_velocity, angular_velocity,
		step_invalid, input ready);
	modport sink (input valid, pos_x, pos_y, heading, linear_velocity, angular_velocity,
		step_invalid, output ready);
endinterface

`default_nettype wire

// ===== hdl/ddwo_muldiv.sv =====
// ddwo_muldiv: serial unit for 64-by-32-bit multiply, 64-bit divide and integer square root
// one bit (or bit pair) per cycle; uses ddwo_pkg
`default_nettype none

module ddwo_muldiv (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ddwo_pkg::md_ctrl_t  ctrl,
	input  wire logic [63:0]         a,
	input  wire logic [63:0]         b,
	output logic                     done,
	output logic [63:0]              result
);

	ddwo_pkg::md_op_t op_q;
	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [63:0]      r0_q, r1_q, r2_q;

	logic [64:0] rem_sh;
	logic        ge;
	logic [63:0] trial;

	assign rem_sh = {r0_q, r1_q[63]};
	assign ge = rem_sh >= {1'b0, r2_q};
	assign trial = r1_q + r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= ddwo_pkg::MD_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				op_q <= ctrl.op;
				cnt_q <= (ctrl.op == ddwo_pkg::MD_DIV) ? 6'd63 : 6'd31;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			case (ctrl.op)
				ddwo_pkg::MD_SQRT: begin
					r0_q <= a;
					r1_q <= '0;
					r2_q <= 64'd1 << 62;
				end
				ddwo_pkg::MD_DIV: begin
					r0_q <= '0;
					r1_q <= a;
					r2_q <= b;
				end
				default: begin
					r0_q <= '0;
					r1_q <= a;
					r2_q <= b;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				ddwo_pkg::MD_DIV: begin
					r0_q <= ge ? 64'(rem_sh - {1'b0, r2_q}) : rem_sh[63:0];
					r1_q <= {r1_q[62:0], ge};
				end
				ddwo_pkg::MD_SQRT: begin
					if (r0_q >= trial) begin
						r0_q <= r0_q - trial;
						r1_q <= (r1_q >> 1) + r2_q;
					end else begin
						r1_q <= r1_q >> 1;
					end
					r2_q <= r2_q >> 2;
				end
				default: begin
					if (r2_q[0]) begin
						r0_q <= r0_q + r1_q;
					end
					r1_q <= r1_q << 1;
					r2_q <= r2_q >> 1;
				end
			endcase
		end
	end

	assign done = done_q;
	assign result = (op_q == ddwo_pkg::MD_MUL) ? r0_q : r1_q;

endmodule

`default_nettype wire

// ===== hdl/ddwo_cordic.sv =====
// ddwo_cordic: iterative CORDIC, vectoring (atan) and rotation (sin, cos)
// one micro-rotation per cycle; uses ddwo_pkg
`default_nettype none

module ddwo_cordic #(
	parameter int STEPS = ddwo_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ddwo_pkg::cordic_ctrl_t ctrl,
	input  wire logic signed [33:0]     x0,
	input  wire logic signed [33:0]     y0,
	input  wire logic signed [31:0]     z0,
	output logic                        done,
	output logic signed [33:0]          x,
	output logic signed [33:0]          y,
	output logic signed [31:0]          z
);

	localparam int STEP_W = $clog2(STEPS);

	ddwo_pkg::cordic_mode_t mode_q;
	logic                   busy_q;
	logic                   done_q;
	logic [STEP_W-1:0]      cnt_q;
	logic signed [33:0]     x_q, y_q;
	logic signed [31:0]     z_q;

	logic signed [33:0] dx, dy;
	logic signed [31:0] at;
	logic               add_dir;

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign at = ddwo_pkg::atan_q28(5'(cnt_q));
	assign add_dir = (mode_q == ddwo_pkg::CM_VECTOR) ? !y_q[33] : z_q[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= ddwo_pkg::CM_VECTOR;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				mode_q <= ctrl.mode;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (add_dir) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
	end

	assign done = done_q;
	assign x = x_q;
	assign y = y_q;
	assign z = z_q;

endmodule

`default_nettype wire

// ===== hdl/diff_drive_wheel_odometry.sv =====
// diff_drive_wheel_odometry: top level, sequencer and state of the odometry block
// uses ddwo_pkg, ddwo_if, ddwo_muldiv and ddwo_cordic
//
// Count words (left, right) form a wrap-corrected delta from the wheel's last
// count, scale it by meters_per_tick and add it to that wheel's distance; a
// start word zeroes the pose; an update word (after start) runs arc odometry
// and returns one result word with pose and velocities. All arithmetic runs on
// one serial multiply/divide/sqrt unit (one bit or bit pair per cycle) and one
// iterative CORDIC, under a sequencer that takes one word at a time. Each word
// holds off the next until the sequencer is back in idle: a start word or a
// skipped count the least, an update word the most, less when the turn argument
// is above one or the elapsed time is zero, more while the previous result still
// waits. req.ready is high only while idle; a finished result waits in the
// output register while later words are taken.
`default_nettype none

module diff_drive_wheel_odometry #(
	parameter int          CORDIC_STEPS = ddwo_pkg::CORDIC_STEPS_DEF,
	parameter logic [32:0] COUNTER_SPAN = ddwo_pkg::COUNTER_SPAN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data,
	ddwo_in_if.sink          req,
	ddwo_out_if.source       rsp
);

	ddwo_pkg::state_t state_q, state_d;

	logic [31:0] mpt_q, iwb_q;
	logic [14:0] wrap_q;

	logic [15:0]        last_left_q, last_right_q;
	logic signed [31:0] left_q, right_q;
	logic signed [31:0] pose_x_q, pose_y_q, heading_q;
	logic               started_q;

	ddwo_pkg::kind_t    kind_q;
	logic signed [15:0] count_q;
	logic [31:0]        elapsed_q;

	logic               d_neg_q;
	logic [31:0]        dist_mag_q;
	logic               dist_neg_q;
	logic               diff_neg_q;
	logic [30:0]        tm_q;
	logic signed [31:0] angle_q;
	logic signed [33:0] avg_q;
	logic               fold_neg_q;
	logic               c_neg_q;
	logic               s_neg_q;
	logic [32:0]        s_mag_q;
	logic signed [31:0] vl_q, va_q;
	logic               inv_q;

	logic               out_valid_q;
	logic signed [31:0] out_x_q, out_y_q, out_vl_q, out_va_q;
	logic signed [30:0] out_h_q;
	logic               out_inv_q;

	ddwo_pkg::md_ctrl_t     mdc;
	logic [63:0]            md_a, md_b, md_res;
	logic                   md_done;
	ddwo_pkg::cordic_ctrl_t cc;
	logic signed [33:0]     cx0, cy0, cx, cy;
	logic signed [31:0]     cz0, cz;
	logic                   c_done;

	logic               accept;
	logic               is_right;
	logic signed [15:0] prev_s;
	logic               skip;
	logic signed [16:0] d17;
	logic signed [17:0] lim18;
	logic signed [33:0] span34, d34, dsat;
	logic [33:0]        dabs;

	logic signed [32:0] sum33, diff33;
	logic [32:0]        sum_mag, diff_mag;
	logic [32:0]        dist_m;

	logic [63:0]        tm64;
	logic signed [33:0] t34;
	logic [47:0]        cnt_m;
	logic signed [65:0] acc_sum;
	logic signed [31:0] acc_sel;

	logic signed [33:0] avg_raw, fold_z;
	logic               fold_neg;
	logic [33:0]        x_abs, y_abs;
	logic [63:0]        rnd_p;
	logic signed [65:0] pos_sum;
	logic signed [31:0] pos_sel;
	logic               pos_neg;
	logic signed [33:0] head_new;
	logic [63:0]        den_va;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ddwo_pkg::ST_IDLE);

	// count delta with wrap correction
	assign is_right = (kind_q == ddwo_pkg::KIND_RIGHT);
	assign prev_s = is_right ? $signed(last_right_q) : $signed(last_left_q);
	assign skip = (count_q == 16'sd0) || (prev_s == 16'sd0);
	assign d17 = 17'(count_q) - 17'(prev_s);
	assign lim18 = $signed({3'b000, wrap_q});
	assign span34 = $signed({1'b0, COUNTER_SPAN});

	always_comb begin
		if (18'(d17) > lim18) begin
			d34 = 34'(d17) - span34;
		end else if (18'(d17) < -lim18) begin
			d34 = 34'(d17) + span34;
		end else begin
			d34 = 34'(d17);
		end
		if (d34 > 34'sd2147483647) begin
			dsat = 34'sd2147483647;
		end else if (d34 < -34'sd2147483647) begin
			dsat = -34'sd2147483647;
		end else begin
			dsat = d34;
		end
		dabs = dsat[33] ? 34'(-dsat) : 34'(dsat);
	end

	// accumulate scaled delta
	assign acc_sel = is_right ? right_q : left_q;
	assign cnt_m = 48'((md_res + 64'd32768) >> 16);
	assign acc_sum = 66'(acc_sel) + (d_neg_q ? -$signed({18'd0, cnt_m}) :
		$signed({18'd0, cnt_m}));

	// cycle distance and wheel difference
	assign sum33 = 33'(right_q) + 33'(left_q);
	assign diff33 = 33'(right_q) - 33'(left_q);
	assign sum_mag = sum33[32] ? 33'(-sum33) : 33'(sum33);
	assign diff_mag = diff33[32] ? 33'(-diff33) : 33'(diff33);
	assign dist_m = (sum_mag + 33'd1) >> 1;

	assign tm64 = (md_res + 64'd512) >> 10;
	assign t34 = diff_neg_q ? -$signed({3'b000, tm_q}) : $signed({3'b000, tm_q});

	assign avg_raw = 34'(angle_q >>> 1) + 34'(heading_q);

	always_comb begin
		if (avg_q > ddwo_pkg::HALF_PI_Q28) begin
			fold_z = avg_q - ddwo_pkg::PI_Q28;
			fold_neg = 1'b1;
		end else if (avg_q < -ddwo_pkg::HALF_PI_Q28) begin
			fold_z = avg_q + ddwo_pkg::PI_Q28;
			fold_neg = 1'b1;
		end else begin
			fold_z = avg_q;
			fold_neg = 1'b0;
		end
	end

	assign x_abs = cx[33] ? 34'(-cx) : 34'(cx);
	assign y_abs = cy[33] ? 34'(-cy) : 34'(cy);

	// position increment, rounded half away from zero
	assign rnd_p = (md_res + (64'd1 << 29)) >> 30;
	assign pos_neg = ((state_q == ddwo_pkg::ST_U_MX) ? c_neg_q : s_neg_q) ^ dist_neg_q;
	assign pos_sel = (state_q == ddwo_pkg::ST_U_MX) ? pose_x_q : pose_y_q;
	assign pos_sum = 66'(pos_sel) + (pos_neg ? -$signed({2'b00, rnd_p}) : $signed({2'b00, rnd_p}));
	assign head_new = ddwo_pkg::wrap_angle(34'(heading_q) + 34'(angle_q));
	assign den_va = {20'd0, elapsed_q, 12'd0};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ddwo_pkg::ST_IDLE: begin
				if (accept) state_d = ddwo_pkg::ST_DECODE;
			end
			ddwo_pkg::ST_DECODE: begin
				case (kind_q)
					ddwo_pkg::KIND_LEFT, ddwo_pkg::KIND_RIGHT: begin
						state_d = skip ? ddwo_pkg::ST_IDLE : ddwo_pkg::ST_CNT_MUL;
					end
					ddwo_pkg::KIND_UPDATE: begin
						state_d = started_q ? ddwo_pkg::ST_U_DIFF : ddwo_pkg::ST_IDLE;
					end
					default: state_d = ddwo_pkg::ST_IDLE;
				endcase
			end
			ddwo_pkg::ST_CNT_MUL: begin
				if (md_done) state_d = ddwo_pkg::ST_IDLE;
			end
			ddwo_pkg::ST_U_DIFF: state_d = ddwo_pkg::ST_U_AM;
			ddwo_pkg::ST_U_AM: begin
				if (md_done) begin
					state_d = (md_res > ddwo_pkg::ONE_Q40) ? ddwo_pkg::ST_FINISH : ddwo_pkg::ST_U_SQ;
				end
			end
			ddwo_pkg::ST_U_SQ: begin
				if (md_done) state_d = ddwo_pkg::ST_U_SQRT;
			end
			ddwo_pkg::ST_U_SQRT: begin
				if (md_done) state_d = ddwo_pkg::ST_U_ATAN;
			end
			ddwo_pkg::ST_U_ATAN: begin
				if (c_done) state_d = ddwo_pkg::ST_U_WRAP;
			end
			ddwo_pkg::ST_U_WRAP: state_d = ddwo_pkg::ST_U_FOLD;
			ddwo_pkg::ST_U_FOLD: state_d = ddwo_pkg::ST_U_ROT;
			ddwo_pkg::ST_U_ROT: begin
				if (c_done) state_d = ddwo_pkg::ST_U_MX;
			end
			ddwo_pkg::ST_U_MX: begin
				if (md_done) state_d = ddwo_pkg::ST_U_MY;
			end
			ddwo_pkg::ST_U_MY: begin
				if (md_done) begin
					state_d = (elapsed_q == 32'd0) ? ddwo_pkg::ST_FINISH : ddwo_pkg::ST_U_VL;
				end
			end
			ddwo_pkg::ST_U_VL: begin
				if (md_done) state_d = ddwo_pkg::ST_U_VLDIV;
			end
			ddwo_pkg::ST_U_VLDIV: begin
				if (md_done) state_d = ddwo_pkg::ST_U_VA;
			end
			ddwo_pkg::ST_U_VA: begin
				if (md_done) state_d = ddwo_pkg::ST_U_VADIV;
			end
			ddwo_pkg::ST_U_VADIV: begin
				if (md_done) state_d = ddwo_pkg::ST_FINISH;
			end
			ddwo_pkg::ST_FINISH: begin
				if (!out_valid_q || rsp.ready) state_d = ddwo_pkg::ST_IDLE;
			end
			default: state_d = ddwo_pkg::ST_IDLE;
		endcase
	end

	// unit launches
	always_comb begin
		mdc = '{start: 1'b0, op: ddwo_pkg::MD_MUL};
		md_a = '0;
		md_b = '0;
		cc = '{start: 1'b0, mode: ddwo_pkg::CM_VECTOR};
		cx0 = '0;
		cy0 = '0;
		cz0 = '0;
		case (state_q)
			ddwo_pkg::ST_DECODE: begin
				if ((kind_q == ddwo_pkg::KIND_LEFT || kind_q == ddwo_pkg::KIND_RIGHT) && !skip) begin
					mdc.start = 1'b1;
					md_a = {33'd0, dabs[30:0]};
					md_b = {32'd0, mpt_q};
				end
			end
			ddwo_pkg::ST_U_DIFF: begin
				mdc.start = 1'b1;
				md_a = {31'd0, diff_mag};
				md_b = {32'd0, iwb_q};
			end
			ddwo_pkg::ST_U_AM: begin
				if (md_done && md_res <= ddwo_pkg::ONE_Q40) begin
					mdc.start = 1'b1;
					md_a = {33'd0, tm64[30:0]};
					md_b = {33'd0, tm64[30:0]};
				end
			end
			ddwo_pkg::ST_U_SQ: begin
				if (md_done) begin
					mdc = '{start: 1'b1, op: ddwo_pkg::MD_SQRT};
					md_a = ddwo_pkg::ONE_Q60 - md_res;
				end
			end
			ddwo_pkg::ST_U_SQRT: begin
				if (md_done) begin
					cc = '{start: 1'b1, mode: ddwo_pkg::CM_VECTOR};
					cx0 = $signed({3'b000, md_res[30:0]});
					cy0 = t34;
				end
			end
			ddwo_pkg::ST_U_FOLD: begin
				cc = '{start: 1'b1, mode: ddwo_pkg::CM_ROTATE};
				cx0 = ddwo_pkg::GAIN_Q30;
				cz0 = fold_z[31:0];
			end
			ddwo_pkg::ST_U_ROT: begin
				if (c_done) begin
					mdc.start = 1'b1;
					md_a = {30'd0, x_abs};
					md_b = {32'd0, dist_mag_q};
				end
			end
			ddwo_pkg::ST_U_MX: begin
				if (md_done) begin
					mdc.start = 1'b1;
					md_a = {31'd0, s_mag_q};
					md_b = {32'd0, dist_mag_q};
				end
			end
			ddwo_pkg::ST_U_MY: begin
				if (md_done && elapsed_q != 32'd0) begin
					mdc.start = 1'b1;
					md_a = {32'd0, dist_mag_q};
					md_b = ddwo_pkg::USEC_PER_SEC;
				end
			end
			ddwo_pkg::ST_U_VL: begin
				if (md_done) begin
					mdc = '{start: 1'b1, op: ddwo_pkg::MD_DIV};
					md_a = md_res + {33'd0, elapsed_q[31:1]};
					md_b = {32'd0, elapsed_q};
				end
			end
			ddwo_pkg::ST_U_VLDIV: begin
				if (md_done) begin
					mdc.start = 1'b1;
					md_a = {32'd0, angle_q[31] ? 32'(-angle_q) : 32'(angle_q)};
					md_b = ddwo_pkg::USEC_PER_SEC;
				end
			end
			ddwo_pkg::ST_U_VA: begin
				if (md_done) begin
					mdc = '{start: 1'b1, op: ddwo_pkg::MD_DIV};
					md_a = md_res + (den_va >> 1);
					md_b = den_va;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddwo_pkg::ST_IDLE;
			mpt_q <= ddwo_pkg::MPT_RESET;
			iwb_q <= ddwo_pkg::IWB_RESET;
			wrap_q <= ddwo_pkg::WRAP_RESET;
			last_left_q <= '0;
			last_right_q <= '0;
			left_q <= '0;
			right_q <= '0;
			pose_x_q <= '0;
			pose_y_q <= '0;
			heading_q <= '0;
			started_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					ddwo_pkg::REG_MPT:  mpt_q <= wr_data;
					ddwo_pkg::REG_IWB:  iwb_q <= wr_data;
					ddwo_pkg::REG_WRAP: wrap_q <= wr_data[14:0];
					default: begin
					end
				endcase
			end
			if (state_q == ddwo_pkg::ST_FINISH && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ddwo_pkg::ST_DECODE: begin
					case (kind_q)
						ddwo_pkg::KIND_LEFT:  last_left_q <= count_q;
						ddwo_pkg::KIND_RIGHT: last_right_q <= count_q;
						ddwo_pkg::KIND_START: begin
							pose_x_q <= '0;
							pose_y_q <= '0;
							heading_q <= '0;
							started_q <= 1'b1;
						end
						default: begin
						end
					endcase
				end
				ddwo_pkg::ST_CNT_MUL: begin
					if (md_done) begin
						if (is_right) right_q <= ddwo_pkg::sat32(acc_sum);
						else left_q <= ddwo_pkg::sat32(acc_sum);
					end
				end
				ddwo_pkg::ST_U_DIFF: begin
					left_q <= '0;
					right_q <= '0;
				end
				ddwo_pkg::ST_U_MX: begin
					if (md_done) pose_x_q <= ddwo_pkg::sat32(pos_sum);
				end
				ddwo_pkg::ST_U_MY: begin
					if (md_done) begin
						pose_y_q <= ddwo_pkg::sat32(pos_sum);
						heading_q <= head_new[31:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= ddwo_pkg::kind_t'(req.kind);
			count_q <= req.count;
			elapsed_q <= req.elapsed_us;
		end
		case (state_q)
			ddwo_pkg::ST_DECODE: d_neg_q <= dsat[33];
			ddwo_pkg::ST_U_DIFF: begin
				dist_mag_q <= dist_m[31:0];
				dist_neg_q <= sum33[32];
				diff_neg_q <= diff33[32];
				inv_q <= 1'b0;
				vl_q <= '0;
				va_q <= '0;
			end
			ddwo_pkg::ST_U_AM: begin
				if (md_done) begin
					tm_q <= tm64[30:0];
					if (md_res > ddwo_pkg::ONE_Q40) inv_q <= 1'b1;
				end
			end
			ddwo_pkg::ST_U_ATAN: begin
				if (c_done) angle_q <= cz;
			end
			ddwo_pkg::ST_U_WRAP: avg_q <= ddwo_pkg::wrap_angle(avg_raw);
			ddwo_pkg::ST_U_FOLD: fold_neg_q <= fold_neg;
			ddwo_pkg::ST_U_ROT: begin
				if (c_done) begin
					c_neg_q <= cx[33] ^ fold_neg_q;
					s_neg_q <= cy[33] ^ fold_neg_q;
					s_mag_q <= y_abs[32:0];
				end
			end
			ddwo_pkg::ST_U_MY: begin
				if (md_done && elapsed_q == 32'd0) inv_q <= 1'b1;
			end
			ddwo_pkg::ST_U_VLDIV: begin
				if (md_done) vl_q <= ddwo_pkg::sat_mag(dist_neg_q, md_res);
			end
			ddwo_pkg::ST_U_VADIV: begin
				if (md_done) va_q <= ddwo_pkg::sat_mag(angle_q[31], md_res);
			end
			ddwo_pkg::ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_x_q <= pose_x_q;
					out_y_q <= pose_y_q;
					out_h_q <= heading_q[30:0];
					out_vl_q <= vl_q;
					out_va_q <= va_q;
					out_inv_q <= inv_q;
				end
			end
			default: begin
			end
		endcase
	end

	ddwo_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mdc),
		.a      (md_a),
		.b      (md_b),
		.done   (md_done),
		.result (md_res)
	);

	ddwo_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cc),
		.x0     (cx0),
		.y0     (cy0),
		.z0     (cz0),
		.done   (c_done),
		.x      (cx),
		.y      (cy),
		.z      (cz)
	);

	assign rsp.valid = out_valid_q;
	assign rsp.pos_x = out_x_q;
	assign rsp.pos_y = out_y_q;
	assign rsp.heading = out_h_q;
	assign rsp.linear_velocity = out_vl_q;
	assign rsp.angular_velocity = out_va_q;
	assign rsp.step_invalid = out_inv_q;

endmodule

`default_nettype wire

// ===== tb/sv/diff_drive_wheel_odometry_tb.sv =====
// diff_drive_wheel_odometry_tb: self-checking bench for the wheel odometry block
// drives count, start and update words, predicts each pose word, compares field by field
// depends on ddwo_pkg, ddwo_if and the diff_drive_wheel_odometry rtl
`default_nettype none

module diff_drive_wheel_odometry_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ddwo_pkg::*;

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [30:0] heading;
		logic signed [31:0] linear_velocity;
		logic signed [31:0] angular_velocity;
		logic               step_invalid;
	} pose_word_t;

	typedef struct {
		kind_t              kind;
		logic signed [15:0] count;
		logic [31:0]        elapsed_us;
		bit                 typed_invalid;
	} stim_row_t;

	localparam longint ANG_PI = 843314857;
	localparam longint ANG_HALF_PI = 421657428;
	localparam longint ANG_TWO_PI = 1686629713;
	localparam longint ROT_GAIN = 652032874;
	localparam longint WHEEL_SPAN = 65536;
	localparam int STEPS = 24;
	localparam int SETTLE_CYCLES = 600;

	localparam longint ATAN_LUT [32] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
		2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0
	};

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;

	ddwo_in_if  req_if();
	ddwo_out_if rsp_if();

	diff_drive_wheel_odometry dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.req(req_if),
		.rsp(rsp_if)
	);

	// predictor state
	longint unsigned m_per_tick, inv_base, wrap_lim;
	logic [15:0] prev_left, prev_right;
	int left_acc, right_acc, px, py, ph;
	bit running;

	pose_word_t pending_poses[$];
	int errors = 0;
	bit out_burst = 0;
	logic [15:0] gen_left, gen_right;

	function automatic longint unsigned magn(longint v);
		return v < 0 ? 64'd0 - longint'(v) : v;
	endfunction

	function automatic longint with_sign(bit neg, longint unsigned m);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		longint unsigned m;
		m = (magn(v) + (64'd1 << (s - 1))) >> s;
		return with_sign(v < 0, m);
	endfunction

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic longint fold_angle(longint a);
		if (a > ANG_PI) return a - ANG_TWO_PI;
		if (a < -ANG_PI) return a + ANG_TWO_PI;
		return a;
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(longint x, longint y);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_LUT[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_LUT[i];
			end
		end
		return z;
	endfunction

	task automatic rotate_unit(input longint z, output longint c, output longint s);
		bit neg;
		longint x, y, dx, dy;
		neg = 0;
		x = ROT_GAIN;
		y = 0;
		if (z > ANG_HALF_PI) begin
			z -= ANG_PI; neg = 1;
		end else if (z < -ANG_HALF_PI) begin
			z += ANG_PI; neg = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_LUT[i];
			end else begin
				x += dx; y -= dy; z += ATAN_LUT[i];
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	task automatic add_wheel_ticks(inout logic [15:0] last, inout int acc,
		input logic [15:0] raw);
		longint cnt, prev, d, lim;
		longint unsigned m;
		cnt = longint'($signed(raw));
		prev = longint'($signed(last));
		if (cnt != 0 && prev != 0) begin
			d = cnt - prev;
			lim = longint'(wrap_lim);
			if (d > lim) d -= WHEEL_SPAN;
			else if (d < -lim) d += WHEEL_SPAN;
			if (d > 64'sd2147483647) d = 64'sd2147483647;
			if (d < -64'sd2147483647) d = -64'sd2147483647;
			m = (magn(d) * m_per_tick + 64'd32768) >> 16;
			acc = clamp32(longint'(acc) + with_sign(d < 0, m));
		end
		last = raw;
	endtask

	task automatic predict_pose(input kind_t k, input logic [15:0] cnt, input logic [31:0] e,
		output bit has, output pose_word_t w);
		longint r, l, travel, diff, angle, avg, c, s, vl, va, t, rt;
		longint unsigned am, tm, ee;
		bit inv;
		has = 0;
		vl = 0;
		va = 0;
		inv = 0;
		ee = e;
		w = '{default: 0};
		case (k)
			KIND_LEFT: add_wheel_ticks(prev_left, left_acc, cnt);
			KIND_RIGHT: add_wheel_ticks(prev_right, right_acc, cnt);
			KIND_START: begin
				px = 0; py = 0; ph = 0; running = 1;
			end
			default: begin
				if (running) begin
					has = 1;
					r = right_acc;
					l = left_acc;
					travel = rnd_shift(r + l, 1);
					diff = r - l;
					am = magn(diff) * inv_base;
					left_acc = 0;
					right_acc = 0;
					if (am > (64'd1 << 40)) begin
						inv = 1;
					end else begin
						tm = (am + 64'd512) >> 10;
						t = with_sign(diff < 0, tm);
						rt = longint'(root64((64'd1 << 60) - tm * tm));
						angle = vector_angle(rt, t);
						avg = fold_angle((angle >>> 1) + longint'(ph));
						rotate_unit(avg, c, s);
						px = clamp32(longint'(px) + rnd_shift(c * travel, 30));
						py = clamp32(longint'(py) + rnd_shift(s * travel, 30));
						ph = int'(fold_angle(longint'(ph) + angle));
						if (ee == 0) begin
							inv = 1;
						end else begin
							vl = clamp32(with_sign(travel < 0,
								(magn(travel) * 64'd1000000 + ee / 2) / ee));
							va = clamp32(with_sign(angle < 0,
								(magn(angle) * 64'd1000000 + ee * 2048) / (ee * 4096)));
						end
					end
					w.pos_x = px;
					w.pos_y = py;
					w.heading = ph[30:0];
					w.linear_velocity = vl[31:0];
					w.angular_velocity = va[31:0];
					w.step_invalid = inv;
				end
			end
		endcase
	endtask

	function automatic int pick_gap(bit burst);
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(40, 200);
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("TB_ERROR");
		$finish;
	end

	// result side: random stalls
	always @(posedge clk) begin
		int stall;
		if (!arst_n) begin
			rsp_if.ready <= 0;
		end else if (stall > 0) begin
			stall--;
			rsp_if.ready <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if ($urandom_range(0, 49) == 0) out_burst = ~out_burst;
				stall = pick_gap(out_burst);
			end
			rsp_if.ready <= (stall == 0);
		end
	end

	always @(posedge clk) begin
		pose_word_t exp_w;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_poses.size() == 0) begin
				$error("pose word with none expected");
				errors++;
			end else begin
				exp_w = pending_poses.pop_front();
				if (rsp_if.pos_x !== exp_w.pos_x) begin
					$error("pos_x expected %0d got %0d", exp_w.pos_x, rsp_if.pos_x);
					errors++;
				end
				if (rsp_if.pos_y !== exp_w.pos_y) begin
					$error("pos_y expected %0d got %0d", exp_w.pos_y, rsp_if.pos_y);
					errors++;
				end
				if (rsp_if.heading !== exp_w.heading) begin
					$error("heading expected %0d got %0d", exp_w.heading, rsp_if.heading);
					errors++;
				end
				if (rsp_if.linear_velocity !== exp_w.linear_velocity) begin
					$error("linear_velocity expected %0d got %0d",
						exp_w.linear_velocity, rsp_if.linear_velocity);
					errors++;
				end
				if (rsp_if.angular_velocity !== exp_w.angular_velocity) begin
					$error("angular_velocity expected %0d got %0d",
						exp_w.angular_velocity, rsp_if.angular_velocity);
					errors++;
				end
				if (rsp_if.step_invalid !== exp_w.step_invalid) begin
					$error("step_invalid expected %0d got %0d",
						exp_w.step_invalid, rsp_if.step_invalid);
					errors++;
				end
			end
		end
	end

	task automatic send_word(input kind_t k, input logic [15:0] cnt, input logic [31:0] e,
		input bit typed_inv, input bit burst);
		bit has;
		pose_word_t w;
		int gap;
		req_if.valid <= 1;
		req_if.kind <= k;
		req_if.count <= cnt;
		req_if.elapsed_us <= e;
		do @(posedge clk); while (!req_if.ready);
		predict_pose(k, cnt, e, has, w);
		if (has) begin
			if (typed_inv) begin
				w.step_invalid = 1;
				w.linear_velocity = 0;
				w.angular_velocity = 0;
			end
			pending_poses.push_back(w);
		end
		gap = pick_gap(burst);
		if (gap > 0) begin
			req_if.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		req_if.valid <= 0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_t idx, input logic [31:0] val);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 0;
		case (idx)
			REG_MPT: m_per_tick = val;
			REG_IWB: inv_base = val;
			default: wrap_lim = val[14:0];
		endcase
		@(posedge clk);
	endtask

	task automatic next_count(inout logic [15:0] g, output logic [15:0] cnt);
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) cnt = g + 16'($signed($urandom_range(0, 120)) - 60);
		else if (r < 94) cnt = 0;
		else cnt = $urandom;
		g = cnt;
	endtask

	task automatic random_phase(input int n);
		int r;
		bit burst;
		kind_t k;
		logic [15:0] cnt;
		logic [31:0] e;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 39) == 0) burst = ~burst;
			if (i == n / 2) drain();
			r = $urandom_range(0, 99);
			e = $urandom_range(1, 200000);
			if ($urandom_range(0, 9) == 0) e = 0;
			else if ($urandom_range(0, 4) == 0) e = $urandom;
			if (r < 85) begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					k = KIND_LEFT; next_count(gen_left, cnt);
				end else if (r < 80) begin
					k = KIND_RIGHT; next_count(gen_right, cnt);
				end else if (r < 97) begin
					k = KIND_UPDATE; cnt = $urandom;
				end else begin
					k = KIND_START; cnt = $urandom;
				end
			end else begin
				k = kind_t'($urandom_range(0, 3));
				cnt = $urandom;
				e = $urandom;
				if (k == KIND_LEFT) gen_left = cnt;
				if (k == KIND_RIGHT) gen_right = cnt;
			end
			send_word(k, cnt, e, 0, burst);
		end
	endtask

	stim_row_t directed[] = '{
		'{KIND_UPDATE, 16'sd0, 32'd1000, 0},
		'{KIND_LEFT, 16'sd0, 32'd0, 0},
		'{KIND_LEFT, 16'sd100, 32'd0, 0},
		'{KIND_RIGHT, 16'sd100, 32'd0, 0},
		'{KIND_START, 16'sd0, 32'd0, 0},
		'{KIND_UPDATE, 16'sd0, 32'd100000, 0},
		'{KIND_LEFT, 16'sd150, 32'd0, 0},
		'{KIND_RIGHT, 16'sd250, 32'd0, 0},
		'{KIND_UPDATE, 16'sd0, 32'd100000, 0},
		'{KIND_LEFT, 16'sd32767, 32'd0, 0},
		'{KIND_LEFT, -16'sd32768, 32'd0, 0},
		'{KIND_RIGHT, -16'sd32768, 32'd0, 0},
		'{KIND_RIGHT, 16'sd32767, 32'd0, 0},
		'{KIND_UPDATE, 16'sd0, 32'd0, 1},
		'{KIND_RIGHT, 16'sd2300, 32'd0, 0},
		'{KIND_UPDATE, 16'sd0, 32'd50000, 1},
		'{KIND_UPDATE, 16'sd0, 32'hffffffff, 0},
		'{KIND_RIGHT, 16'sd2400, 32'd0, 0},
		'{KIND_UPDATE, 16'sd0, 32'd1, 0},
		'{KIND_LEFT, -16'sd100, 32'd0, 0},
		'{KIND_LEFT, -16'sd32768, 32'd0, 0},
		'{KIND_UPDATE, 16'sd0, 32'd1, 0},
		'{KIND_START, 16'sd0, 32'd0, 0},
		'{KIND_UPDATE, 16'sd0, 32'd1000, 0}
	};

	initial begin
		arst_n = 0;
		wr_en = 0;
		wr_index = REG_MPT;
		wr_data = 0;
		req_if.valid = 0;
		req_if.kind = KIND_LEFT;
		req_if.count = 0;
		req_if.elapsed_us = 0;
		m_per_tick = MPT_RESET;
		inv_base = IWB_RESET;
		wrap_lim = WRAP_RESET;
		prev_left = 0;
		prev_right = 0;
		left_acc = 0;
		right_acc = 0;
		px = 0;
		py = 0;
		ph = 0;
		running = 0;
		gen_left = 16'd1000;
		gen_right = 16'd1000;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i])
			send_word(directed[i].kind, directed[i].count, directed[i].elapsed_us,
				directed[i].typed_invalid, 0);
		drain();

		random_phase(350);
		drain();

		write_reg(REG_MPT, 32'd1);
		write_reg(REG_IWB, 32'd1);
		write_reg(REG_WRAP, 32'd0);
		random_phase(250);
		drain();

		write_reg(REG_MPT, 32'hffffffff);
		write_reg(REG_IWB, 32'hffffffff);
		write_reg(REG_WRAP, 32'd32767);
		random_phase(250);
		drain();

		write_reg(REG_MPT, $urandom_range(100000, 3000000));
		write_reg(REG_IWB, $urandom_range(20000000, 200000000));
		write_reg(REG_WRAP, $urandom_range(1000, 30000));
		random_phase(350);
		drain();

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
